// ----- hdl/fpps_pkg.sv -----
`timescale 1ns / 1ps
// fpps_pkg: shared types and constants for the fitness proportionate parent select core.
// No dependencies; used by fpps_mul, fpps_seq and the top level in hdl/.

package fpps_pkg;

  // default group storage depth
  localparam int DEF_MAX_MEMBERS = 1024;

  // field widths
  localparam int WEIGHT_W   = 20;
  localparam int DRAW_W     = 32;
  localparam int SUM_W      = 30;
  localparam int IDX_OUT_W  = 10;
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 11;

  // shared multiplier: draw times one 15-bit slice of the 30-bit scale
  localparam int MUL_B_W = SUM_W / 2;
  localparam int PROD_W  = DRAW_W + MUL_B_W;
  localparam int ACC_W   = DRAW_W + SUM_W;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // register indexes on the configuration channel
  localparam logic [CFG_ADDR_W-1:0] REG_TWO_SEXES  = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FIRST_MALE = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GROUP_SIZE = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FITNESS    = 8'd3;

  // reset values of the configuration registers
  localparam logic [CFG_DATA_W-1:0] RST_FIRST_MALE = 11'd512;
  localparam logic [CFG_DATA_W-1:0] RST_GROUP_SIZE = 11'd1024;

  // func codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SELECT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SETUP,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_SRCH,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  two_sexes;
    logic [CFG_DATA_W-1:0] first_male;
    logic [CFG_DATA_W-1:0] group_size;
    logic                  fitness;
  } cfg_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] pick_index;
    logic                 empty_range;
  } result_t;

endpackage

// ----- hdl/fpps_ram.sv -----
`timescale 1ns / 1ps
// fpps_ram: cumulative weight table, one write port and one registered read port.
// Depends on nothing; sized by the instantiating module.

module fpps_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 30
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/fpps_mul.sv -----
`timescale 1ns / 1ps
// fpps_mul: shared 32 x 15 unsigned multiplier with registered product.
// Depends on fpps_pkg for widths.

module fpps_mul (
  input  logic                          clk,
  input  logic [fpps_pkg::DRAW_W-1:0]   a,
  input  logic [fpps_pkg::MUL_B_W-1:0]  b,
  output logic [fpps_pkg::PROD_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= fpps_pkg::PROD_W'(a) * fpps_pkg::PROD_W'(b);
  end

endmodule

// ----- hdl/fpps_seq.sv -----
`timescale 1ns / 1ps
// fpps_seq: sequencer for loads and selects; running sums, draw scaling, binary search.
// Depends on fpps_pkg; drives fpps_ram and fpps_mul from the top level.

module fpps_seq #(
  parameter int MAX_MEMBERS = fpps_pkg::DEF_MAX_MEMBERS,
  parameter int IDX_W       = $clog2(MAX_MEMBERS),
  parameter int CNT_W       = IDX_W + 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fpps_pkg::cfg_t                 cfg,
  // item channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [fpps_pkg::WEIGHT_W-1:0]  in_weight,
  input  logic                           in_restart,
  input  logic                           in_sex,
  input  logic [fpps_pkg::DRAW_W-1:0]    in_draw,
  // result
  input  logic                           out_free,
  output logic                           res_push,
  output fpps_pkg::result_t              res,
  // table
  output logic                           ram_we,
  output logic [IDX_W-1:0]               ram_waddr,
  output logic [fpps_pkg::SUM_W-1:0]     ram_wdata,
  output logic [IDX_W-1:0]               ram_raddr,
  input  logic [fpps_pkg::SUM_W-1:0]     ram_rdata,
  // shared multiplier
  output logic [fpps_pkg::DRAW_W-1:0]    mul_a,
  output logic [fpps_pkg::MUL_B_W-1:0]   mul_b,
  input  logic [fpps_pkg::PROD_W-1:0]    mul_p
);

  fpps_pkg::state_t state, state_next;

  // latched item
  logic                          func;
  logic [fpps_pkg::WEIGHT_W-1:0] weight;
  logic                          restart;
  logic                          sex;
  logic [fpps_pkg::DRAW_W-1:0]   draw;

  // running state
  logic [fpps_pkg::SUM_W-1:0] female_total;
  logic [fpps_pkg::SUM_W-1:0] male_total;
  logic [CNT_W-1:0]           load_count;

  // select datapath
  logic [CNT_W-1:0]           lo, hi, a, b, mid, idx;
  logic [fpps_pkg::SUM_W-1:0] scale;
  logic                       empty;
  logic [fpps_pkg::PROD_W-1:0] prod_lo;
  logic [fpps_pkg::SUM_W-1:0] target;

  // effective group bounds
  logic [CNT_W-1:0] n_eff, fm_eff;

  always_comb begin
    n_eff = (32'(cfg.group_size) > MAX_MEMBERS) ? CNT_W'(MAX_MEMBERS)
                                                : CNT_W'(cfg.group_size);
    fm_eff = (32'(cfg.first_male) > 32'(n_eff)) ? n_eff : CNT_W'(cfg.first_male);
  end

  // load path
  logic [CNT_W-1:0]           ld_idx;
  logic                       ld_male, ld_take;
  logic [fpps_pkg::SUM_W-1:0] ld_base, ld_sum;
  logic [fpps_pkg::SUM_W:0]   ld_raw;

  always_comb begin
    ld_idx  = restart ? '0 : load_count;
    ld_take = ld_idx < n_eff;
    ld_male = cfg.two_sexes && (ld_idx >= fm_eff);
    if (restart) begin
      ld_base = '0;
    end else if (ld_male) begin
      ld_base = male_total;
    end else begin
      ld_base = female_total;
    end
    ld_raw = {1'b0, ld_base} + (fpps_pkg::SUM_W + 1)'(weight);
    ld_sum = ld_raw[fpps_pkg::SUM_W] ? fpps_pkg::SUM_MAX : ld_raw[fpps_pkg::SUM_W-1:0];
  end

  // select setup values
  logic [CNT_W-1:0]           sel_lo, sel_hi;
  logic [fpps_pkg::SUM_W-1:0] sel_total;
  logic                       sel_empty;

  always_comb begin
    if (cfg.two_sexes && sex) begin
      sel_lo = fm_eff;
      sel_hi = n_eff;
      sel_total = male_total;
    end else if (cfg.two_sexes) begin
      sel_lo = '0;
      sel_hi = fm_eff;
      sel_total = female_total;
    end else begin
      sel_lo = '0;
      sel_hi = n_eff;
      sel_total = female_total;
    end
    sel_empty = (sel_hi <= sel_lo) || (cfg.fitness && (sel_total == '0));
  end

  // (draw * scale) >> 32 from the two partial products
  logic [fpps_pkg::ACC_W-1:0] acc;

  always_comb begin
    acc = fpps_pkg::ACC_W'(prod_lo) + {mul_p, {fpps_pkg::MUL_B_W{1'b0}}};
  end

  always_comb begin
    mid = a + ((b - a) >> 1);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fpps_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_func == fpps_pkg::FUNC_LOAD) ? fpps_pkg::ST_LOAD
                                                         : fpps_pkg::ST_SETUP;
        end
      end
      fpps_pkg::ST_LOAD:   state_next = fpps_pkg::ST_IDLE;
      fpps_pkg::ST_SETUP:  state_next = sel_empty ? fpps_pkg::ST_DONE : fpps_pkg::ST_MUL_LO;
      fpps_pkg::ST_MUL_LO: state_next = fpps_pkg::ST_MUL_HI;
      fpps_pkg::ST_MUL_HI: state_next = fpps_pkg::ST_SUM;
      fpps_pkg::ST_SUM:    state_next = cfg.fitness ? fpps_pkg::ST_SRCH : fpps_pkg::ST_DONE;
      fpps_pkg::ST_SRCH:   state_next = (a < b) ? fpps_pkg::ST_CMP : fpps_pkg::ST_DONE;
      fpps_pkg::ST_CMP:    state_next = fpps_pkg::ST_SRCH;
      fpps_pkg::ST_DONE:   state_next = out_free ? fpps_pkg::ST_IDLE : fpps_pkg::ST_DONE;
      default:             state_next = fpps_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    res_push  = 1'b0;
    ram_we    = 1'b0;
    mul_b     = scale[fpps_pkg::MUL_B_W-1:0];
    unique case (state)
      fpps_pkg::ST_IDLE:   in_ready = 1'b1;
      fpps_pkg::ST_LOAD:   ram_we = ld_take;
      fpps_pkg::ST_MUL_HI: mul_b = scale[fpps_pkg::SUM_W-1:fpps_pkg::MUL_B_W];
      fpps_pkg::ST_DONE:   res_push = out_free;
      default: ;
    endcase
  end

  assign mul_a     = draw;
  assign ram_waddr = ld_idx[IDX_W-1:0];
  assign ram_wdata = ld_sum;
  assign ram_raddr = mid[IDX_W-1:0];
  assign res.pick_index  = empty ? '0 : fpps_pkg::IDX_OUT_W'(idx);
  assign res.empty_range = empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // running sums and load count; restart clears the sum that the load does not take
  always_ff @(posedge clk) begin
    if (rst) begin
      female_total <= '0;
      male_total   <= '0;
      load_count   <= '0;
    end else if (state == fpps_pkg::ST_LOAD) begin
      if (ld_take) begin
        if (ld_male) begin
          male_total <= ld_sum;
          if (restart) begin
            female_total <= '0;
          end
        end else begin
          female_total <= ld_sum;
          if (restart) begin
            male_total <= '0;
          end
        end
        load_count <= ld_idx + 1'b1;
      end else if (restart) begin
        female_total <= '0;
        male_total   <= '0;
        load_count   <= '0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (state)
      fpps_pkg::ST_IDLE: begin
        if (in_valid) begin
          func    <= in_func;
          weight  <= in_weight;
          restart <= in_restart;
          sex     <= in_sex;
          draw    <= in_draw;
        end
      end
      fpps_pkg::ST_SETUP: begin
        lo    <= sel_lo;
        hi    <= sel_hi;
        empty <= sel_empty;
        scale <= cfg.fitness ? sel_total : fpps_pkg::SUM_W'(sel_hi - sel_lo);
      end
      fpps_pkg::ST_MUL_HI: prod_lo <= mul_p;
      fpps_pkg::ST_SUM: begin
        target <= acc[fpps_pkg::ACC_W-1:fpps_pkg::DRAW_W];
        idx    <= lo + CNT_W'(acc[fpps_pkg::ACC_W-1:fpps_pkg::DRAW_W]);
        a      <= lo;
        b      <= hi;
      end
      fpps_pkg::ST_SRCH: begin
        if (a >= b) begin
          idx <= (a >= hi) ? hi - 1'b1 : a;
        end
      end
      fpps_pkg::ST_CMP: begin
        if (func == fpps_pkg::FUNC_SELECT && ram_rdata > target) begin
          b <= mid;
        end else begin
          a <= mid + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/fitness_proportionate_parent_select_core.sv -----
`timescale 1ns / 1ps
// fitness_proportionate_parent_select_core: top level, configuration registers and result register.
// Depends on fpps_pkg, fpps_ram, fpps_mul and fpps_seq.

// Roulette-wheel parent selection for one group. Load transactions (func 0)
// bring member weights in index order; each weight is added, saturating at
// 2^30-1, to its sex's running total and the running value is stored in a
// MAX_MEMBERS x 30 cumulative table. restart on a load clears the count and
// both totals first; loads past the group are dropped. Select transactions
// (func 1) return one result: with fitness selection on, target =
// (draw * total) >> 32 and a binary search finds the first entry of the sex's
// range above target; with it off, index = lo + ((draw * count) >> 32).
// empty_range flags a sex with no members or, by weight, a zero total.
// Flow: one transaction at a time, s_tready is high only when idle. A
// select by weight runs P <= ceil(log2(range + 1)) search probes (at most
// 11 for 1024 members); each probe is an address step and a compare on the
// table's single registered read port. Draw scaling uses one shared
// 32 x 15 multiplier over two passes. The table needs no clearing pass after
// reset. The result sits in an output register, so a select can finish
// while the previous result still waits on m_tready; the core then holds in
// its final state.

module fitness_proportionate_parent_select_core #(
  parameter int MAX_MEMBERS = fpps_pkg::DEF_MAX_MEMBERS
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fpps_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  logic [fpps_pkg::CFG_DATA_W-1:0]   cfg_data,
  // item stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [55:0]                       s_tdata,  // weight[19:0], draw[51:20], zero[55:52]
  input  logic [2:0]                        s_tuser,  // func[0], restart[1], sex[2]
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata,  // pick_index[9:0], zero[15:10]
  output logic                              m_tuser   // empty_range[0]
);

  localparam int IDX_W = $clog2(MAX_MEMBERS);
  localparam int CNT_W = IDX_W + 1;

  fpps_pkg::cfg_t    cfg;
  fpps_pkg::result_t res;
  logic              res_push;

  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr, ram_raddr;
  logic [fpps_pkg::SUM_W-1:0]    ram_wdata, ram_rdata;
  logic [fpps_pkg::DRAW_W-1:0]   mul_a;
  logic [fpps_pkg::MUL_B_W-1:0]  mul_b;
  logic [fpps_pkg::PROD_W-1:0]   mul_p;

  logic [fpps_pkg::IDX_OUT_W-1:0] out_index;
  logic                           out_empty;

  // configuration is always accepted; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.two_sexes  <= 1'b0;
      cfg.first_male <= fpps_pkg::RST_FIRST_MALE;
      cfg.group_size <= fpps_pkg::RST_GROUP_SIZE;
      cfg.fitness    <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fpps_pkg::REG_TWO_SEXES:  cfg.two_sexes  <= cfg_data[0];
        fpps_pkg::REG_FIRST_MALE: cfg.first_male <= cfg_data;
        fpps_pkg::REG_GROUP_SIZE: cfg.group_size <= cfg_data;
        fpps_pkg::REG_FITNESS:    cfg.fitness    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  fpps_seq #(
    .MAX_MEMBERS (MAX_MEMBERS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_func    (s_tuser[0]),
    .in_weight  (s_tdata[19:0]),
    .in_restart (s_tuser[1]),
    .in_sex     (s_tuser[2]),
    .in_draw    (s_tdata[51:20]),
    .out_free   (!m_tvalid || m_tready),
    .res_push   (res_push),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .mul_a      (mul_a),
    .mul_b      (mul_b),
    .mul_p      (mul_p)
  );

  fpps_ram #(
    .DEPTH (MAX_MEMBERS),
    .AW    (IDX_W),
    .DW    (fpps_pkg::SUM_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fpps_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // output register: loaded only when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_index <= res.pick_index;
      out_empty <= res.empty_range;
    end
  end

  assign m_tdata = {6'd0, out_index};
  assign m_tuser = out_empty;

endmodule
